// ===== design/hsnq_pkg.sv =====
// ----------------------------------------------------------------------------
// hsnq_pkg: shared types and constants of the hue to scale note quantizer
// Payload structs, divider request and status, scale tables and register
// indexes used by the core and its helper units.
// ----------------------------------------------------------------------------
package hsnq_pkg;

  // Default commit dwell in ticks.
  localparam int DWELL_TICKS_DEF = 45;

  // Register indexes of the configuration port.
  localparam int CFG_IW = 3;
  localparam logic [CFG_IW-1:0] REG_MIN_BRIGHT = 3'd0;
  localparam logic [CFG_IW-1:0] REG_MIN_CHROMA = 3'd1;
  localparam logic [CFG_IW-1:0] REG_BASE_NOTE  = 3'd2;
  localparam logic [CFG_IW-1:0] REG_TRANSPOSE  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_TRIG_TICKS = 3'd4;

  localparam logic [15:0] MIN_BRIGHT_RST = 16'd6554;
  localparam logic [15:0] MIN_CHROMA_RST = 16'd2048;
  localparam logic [6:0]  BASE_NOTE_RST  = 7'd48;
  localparam logic [3:0]  TRANSPOSE_RST  = 4'd0;
  localparam logic [7:0]  TRIG_TICKS_RST = 8'd15;

  // Hue arithmetic constants.
  localparam logic [14:0] HUE_SCALE   = 15'd10923;
  localparam logic [15:0] HUE_OFS_G   = 16'd21845;
  localparam logic [15:0] HUE_OFS_B   = 16'd43691;
  localparam logic [15:0] HUE_ROTATE  = 16'd5461;
  localparam logic [12:0] ZONE_HYST   = 13'd48;
  localparam logic [12:0] ZONE_UPPER  = 13'd1072;

  // Shared divider geometry.
  localparam int DIV_QW = 14;
  localparam int DIV_RW = 13;
  localparam int DIV_CW = 4;

  typedef struct packed {
    logic [DIV_RW-1:0] rem_init;
    logic [DIV_QW-1:0] low_bits;
    logic [DIV_CW-1:0] count;
    logic [DIV_RW-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

  typedef struct packed {
    logic [15:0] red;
    logic [15:0] green;
    logic [15:0] blue;
    logic [11:0] knob;
  } in_t;

  typedef struct packed {
    logic [6:0] note;
    logic       note_held;
    logic [2:0] led_flash;
    logic       trigger;
    logic       color_valid;
    logic       gate;
  } out_t;

  function automatic logic [3:0] scale_len(input logic [1:0] s);
    logic [3:0] l;
    unique case (s)
      2'd0:    l = 4'd12;
      2'd1:    l = 4'd7;
      2'd2:    l = 4'd7;
      default: l = 4'd5;
    endcase
    return l;
  endfunction

  // Band count 2*len+1.
  function automatic logic [4:0] scale_bands(input logic [1:0] s);
    return {scale_len(s), 1'b1};
  endfunction

  // Band width 65536 / (2*len+1).
  function automatic logic [12:0] scale_band(input logic [1:0] s);
    logic [12:0] b;
    unique case (s)
      2'd0:    b = 13'd2621;
      2'd1:    b = 13'd4369;
      2'd2:    b = 13'd4369;
      default: b = 13'd5957;
    endcase
    return b;
  endfunction

  // Quarter band, rounded down.
  function automatic logic [10:0] scale_qband(input logic [1:0] s);
    logic [10:0] q;
    unique case (s)
      2'd0:    q = 11'd655;
      2'd1:    q = 11'd1092;
      2'd2:    q = 11'd1092;
      default: q = 11'd1489;
    endcase
    return q;
  endfunction

  // Semitone offset of a degree within one octave of a scale.
  function automatic logic [3:0] scale_step(input logic [1:0] s, input logic [3:0] idx);
    logic [3:0] v;
    v = 4'd0;
    unique case (s)
      2'd0: v = idx;
      2'd1: begin
        unique case (idx)
          4'd1:    v = 4'd2;
          4'd2:    v = 4'd4;
          4'd3:    v = 4'd5;
          4'd4:    v = 4'd7;
          4'd5:    v = 4'd9;
          4'd6:    v = 4'd11;
          default: v = 4'd0;
        endcase
      end
      2'd2: begin
        unique case (idx)
          4'd1:    v = 4'd2;
          4'd2:    v = 4'd3;
          4'd3:    v = 4'd5;
          4'd4:    v = 4'd7;
          4'd5:    v = 4'd8;
          4'd6:    v = 4'd10;
          default: v = 4'd0;
        endcase
      end
      default: begin
        unique case (idx)
          4'd1:    v = 4'd2;
          4'd2:    v = 4'd4;
          4'd3:    v = 4'd7;
          4'd4:    v = 4'd9;
          default: v = 4'd0;
        endcase
      end
    endcase
    return v;
  endfunction

endpackage

// ===== design/hsnq_div.sv =====
// ----------------------------------------------------------------------------
// hsnq_div: shared restoring divider
// Produces one quotient bit per cycle. The caller pre-aligns the dividend so
// that the initial partial remainder is already below the divisor.
// ----------------------------------------------------------------------------
module hsnq_div
  import hsnq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  div_req_t          req,
  output div_stat_t         stat,
  output logic [DIV_QW-1:0] quotient
);

  logic [DIV_RW-1:0] rem_r;
  logic [DIV_QW-1:0] low_r;
  logic [DIV_QW-1:0] q_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [DIV_RW-1:0] dsr_r;
  logic              done_r;

  logic [DIV_RW:0]   shifted;
  logic [DIV_RW+1:0] trial;
  logic              fits;

  assign shifted = {rem_r, low_r[DIV_QW-1]};
  assign trial   = {1'b0, shifted} - {2'b00, dsr_r};
  assign fits    = !trial[DIV_RW+1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      // Done rises in the cycle after the last quotient step.
      done_r <= !start && (cnt_r == DIV_CW'(1));
      if (start) begin
        rem_r <= req.rem_init;
        low_r <= req.low_bits;
        q_r   <= '0;
        cnt_r <= req.count;
        dsr_r <= req.divisor;
      end else if (cnt_r != '0) begin
        // The partial remainder stays below the divisor, so it fits DIV_RW bits.
        rem_r  <= fits ? trial[DIV_RW-1:0] : shifted[DIV_RW-1:0];
        low_r  <= {low_r[DIV_QW-2:0], 1'b0};
        q_r    <= {q_r[DIV_QW-2:0], fits};
        cnt_r  <= cnt_r - 1'b1;
      end
    end
  end

  assign stat.busy = (cnt_r != '0);
  assign stat.done = done_r;
  assign quotient  = q_r;

endmodule

// ===== design/hsnq_note.sv =====
// ----------------------------------------------------------------------------
// hsnq_note: degree to note mapping
// Splits a held degree into octave and scale step and forms the saturated
// note number from base note and transpose.
// ----------------------------------------------------------------------------
module hsnq_note
  import hsnq_pkg::*;
(
  input  logic [1:0] scale,
  input  logic [4:0] degree,
  input  logic [6:0] base_note,
  input  logic [3:0] transpose,
  output logic [6:0] note
);

  logic [4:0] len5;
  logic [4:0] two_len;
  logic [4:0] step_idx;
  logic [4:0] octave_semis;
  logic [8:0] sum;

  // A held degree is below 2*len+1, so at most two octaves are removed.
  always_comb begin
    len5    = {1'b0, scale_len(scale)};
    two_len = {len5[3:0], 1'b0};
    if (degree >= two_len) begin
      step_idx     = degree - two_len;
      octave_semis = 5'd24;
    end else if (degree >= len5) begin
      step_idx     = degree - len5;
      octave_semis = 5'd12;
    end else begin
      step_idx     = degree;
      octave_semis = 5'd0;
    end
    sum  = {2'b00, base_note} + {5'b0, transpose} + {4'b0, octave_semis}
         + {5'b0, scale_step(scale, step_idx[3:0])};
    note = (sum > 9'd127) ? 7'd127 : sum[6:0];
  end

endmodule

// ===== design/hue_to_scale_note_quantizer_core.sv =====
// ----------------------------------------------------------------------------
// hue_to_scale_note_quantizer_core: light hue to scale note quantizer
// Maps an RGB light sample to a held scale degree of a knob-chosen scale,
// with zone and band hysteresis, a commit dwell and a trigger pulse.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+-------------------------------
//  in      | input     | in_valid/in_stall  | in_t  red, green, blue, knob
//  out     | output    | out_valid/out_stall| out_t note ... gate
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index (3b), cfg_data (16b)
//
// An invalid or grey sample skips both divisions, and a hue inside the held
// band skips the band search; otherwise the shared divider computes the hue
// quotient (14 bits) and then the band quotient (5 bits), one quotient bit
// per cycle.
// Reset is synchronous and active low; it restores the register defaults and
// clears all tracking state. in_stall stays high from acceptance until the
// result is loaded into the output register, which holds it while out_stall
// is high; the next input transaction may be accepted meanwhile.
module hue_to_scale_note_quantizer_core
  import hsnq_pkg::*;
#(
  parameter int DWELL_TICKS = DWELL_TICKS_DEF
)(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  in_t               in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output out_t              out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [15:0]       cfg_data
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL,
    S_HDIV,
    S_QSEL,
    S_BDIV,
    S_UPD,
    S_OUT
  } state_t;

  state_t state_r;

  // Configuration registers.
  logic [15:0] min_bright_r;
  logic [15:0] min_chroma_r;
  logic [6:0]  base_note_r;
  logic [3:0]  transpose_r;
  logic [7:0]  trig_ticks_r;

  // Tracking state.
  logic [1:0]  cur_scale_r;
  logic        synced_r;
  logic        degree_valid_r;
  logic [4:0]  held_r;
  logic        pend_valid_r;
  logic [4:0]  pend_r;
  logic [7:0]  dwell_r;
  logic [7:0]  trig_cnt_r;

  // Per-transaction working registers.
  logic [11:0] r12_r, g12_r, b12_r;
  logic        bright_ok_r;
  logic [2:0]  flash_r;
  logic        neg_r;
  logic [15:0] offset_r;
  logic [15:0] hue_r;
  logic        color_valid_r;
  logic [4:0]  cand_r;
  logic        out_valid_r;
  out_t        out_data_r;

  // Shared divider.
  logic              div_start;
  div_req_t          div_req;
  div_stat_t         div_stat;
  logic [DIV_QW-1:0] div_q;

  hsnq_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .req      (div_req),
    .stat     (div_stat),
    .quotient (div_q)
  );

  logic [6:0] mapped_note;

  hsnq_note u_note (
    .scale     (cur_scale_r),
    .degree    (held_r),
    .base_note (base_note_r),
    .transpose (transpose_r),
    .note      (mapped_note)
  );

  logic in_accept;
  logic out_free;

  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;
  assign in_stall  = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Knob zone tracking. Before the first transaction the knob's own zone is
  // taken, which always lies inside its hysteresis window.
  logic [1:0]  scale_eff;
  logic [12:0] knob13;
  logic [12:0] zone_base;
  logic        zone_leave;
  logic [15:0] mx16, mn16;
  logic        color_ok;

  always_comb begin
    scale_eff  = synced_r ? cur_scale_r : in_data.knob[11:10];
    knob13     = {1'b0, in_data.knob};
    zone_base  = {1'b0, scale_eff, 10'd0};
    zone_leave = ((scale_eff != 2'd0) && (knob13 < (zone_base - ZONE_HYST)))
               || (knob13 >= (zone_base + ZONE_UPPER));
    mx16 = (in_data.red > in_data.green) ? in_data.red : in_data.green;
    mx16 = (mx16 > in_data.blue) ? mx16 : in_data.blue;
    mn16 = (in_data.red < in_data.green) ? in_data.red : in_data.green;
    mn16 = (mn16 < in_data.blue) ? mn16 : in_data.blue;
    color_ok = (mx16 >= min_bright_r) && ((mx16 - mn16) >= min_chroma_r);
  end

  // Hue sector selection on the 12-bit channels; the earlier channel wins a
  // tie for the maximum. The magnitude of the channel difference is scaled
  // and divided, and the sign is put back afterwards so the quotient
  // truncates toward zero.
  logic [11:0] mx12, mn12, d12;
  logic [12:0] diff;
  logic [11:0] diff_mag;
  logic [15:0] sector_ofs;
  logic [25:0] prod;

  always_comb begin
    mx12 = (r12_r > g12_r) ? r12_r : g12_r;
    mx12 = (mx12 > b12_r) ? mx12 : b12_r;
    mn12 = (r12_r < g12_r) ? r12_r : g12_r;
    mn12 = (mn12 < b12_r) ? mn12 : b12_r;
    d12  = mx12 - mn12;
    if (mx12 == r12_r) begin
      diff       = {1'b0, g12_r} - {1'b0, b12_r};
      sector_ofs = 16'd0;
    end else if (mx12 == g12_r) begin
      diff       = {1'b0, b12_r} - {1'b0, r12_r};
      sector_ofs = HUE_OFS_G;
    end else begin
      diff       = {1'b0, r12_r} - {1'b0, g12_r};
      sector_ofs = HUE_OFS_B;
    end
    diff_mag = diff[12] ? 12'(-diff) : diff[11:0];
    prod     = {14'd0, diff_mag} * {11'd0, HUE_SCALE};
  end

  // Hue from the signed quotient, wrapped to 16 bits and rotated.
  logic [15:0] q16;
  logic [15:0] hue_calc;

  assign q16      = {2'b00, div_q};
  assign hue_calc = offset_r + (neg_r ? (~q16 + 16'd1) : q16) + HUE_ROTATE;

  // Band hysteresis around the held degree, on signed 18-bit values.
  logic [12:0]        band;
  logic [4:0]         n_bands;
  logic signed [17:0] band_lo, band_hi, hue_s;
  logic               in_held_band;
  logic [17:0]        held_base;

  always_comb begin
    band      = scale_band(cur_scale_r);
    n_bands   = scale_bands(cur_scale_r);
    held_base = {13'd0, held_r} * {5'd0, band};
    band_lo   = $signed(held_base) - $signed({7'd0, scale_qband(cur_scale_r)});
    band_hi   = $signed(held_base) + $signed({5'd0, band})
              + $signed({7'd0, scale_qband(cur_scale_r)});
    hue_s     = $signed({2'b00, hue_r});
    in_held_band = degree_valid_r && (hue_s >= band_lo) && (hue_s < band_hi);
  end

  // Divider requests: the hue quotient is known to stay below 2^14 and the
  // band quotient below 2^5, which fixes the pre-alignment of each dividend.
  always_comb begin
    div_start = 1'b0;
    div_req   = '0;
    if (state_r == S_MUL) begin
      div_start        = bright_ok_r && (d12 != 12'd0);
      div_req.rem_init = {1'b0, prod[25:14]};
      div_req.low_bits = prod[13:0];
      div_req.count    = DIV_CW'(14);
      div_req.divisor  = {1'b0, d12};
    end else if (state_r == S_QSEL) begin
      div_start        = !in_held_band;
      div_req.rem_init = {2'b00, hue_r[15:5]};
      div_req.low_bits = {hue_r[4:0], 9'd0};
      div_req.count    = DIV_CW'(5);
      div_req.divisor  = band;
    end
  end

  logic [8:0] dwell_inc;
  logic       trig_now;

  assign dwell_inc = {1'b0, dwell_r} + 9'd1;
  assign trig_now  = (trig_cnt_r != 8'd0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      min_bright_r   <= MIN_BRIGHT_RST;
      min_chroma_r   <= MIN_CHROMA_RST;
      base_note_r    <= BASE_NOTE_RST;
      transpose_r    <= TRANSPOSE_RST;
      trig_ticks_r   <= TRIG_TICKS_RST;
      cur_scale_r    <= 2'd0;
      synced_r       <= 1'b0;
      degree_valid_r <= 1'b0;
      held_r         <= 5'd0;
      pend_valid_r   <= 1'b0;
      pend_r         <= 5'd0;
      dwell_r        <= 8'd0;
      trig_cnt_r     <= 8'd0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_MIN_BRIGHT: min_bright_r <= cfg_data;
          REG_MIN_CHROMA: min_chroma_r <= cfg_data;
          REG_BASE_NOTE:  base_note_r  <= cfg_data[6:0];
          REG_TRANSPOSE:  transpose_r  <= cfg_data[3:0];
          REG_TRIG_TICKS: trig_ticks_r <= cfg_data[7:0];
          default: ;
        endcase
      end

      // The output step reloads the register itself when it is drained.
      if (out_valid_r && !out_stall && (state_r != S_OUT)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_accept) begin
            r12_r       <= in_data.red[15:4];
            g12_r       <= in_data.green[15:4];
            b12_r       <= in_data.blue[15:4];
            bright_ok_r <= color_ok;
            synced_r    <= 1'b1;
            // Leaving a zone drops the held and pending degrees.
            if (zone_leave) begin
              cur_scale_r    <= in_data.knob[11:10];
              degree_valid_r <= 1'b0;
              pend_valid_r   <= 1'b0;
              dwell_r        <= 8'd0;
              flash_r        <= {1'b0, in_data.knob[11:10]} + 3'd1;
            end else begin
              cur_scale_r <= scale_eff;
              flash_r     <= 3'd0;
            end
            state_r <= S_MUL;
          end
        end
        S_MUL: begin
          neg_r    <= diff[12];
          offset_r <= sector_ofs;
          if (bright_ok_r && (d12 != 12'd0)) begin
            color_valid_r <= 1'b1;
            state_r       <= S_HDIV;
          end else begin
            color_valid_r <= 1'b0;
            state_r       <= S_UPD;
          end
        end
        S_HDIV: begin
          if (div_stat.done) begin
            hue_r   <= hue_calc;
            state_r <= S_QSEL;
          end
        end
        S_QSEL: begin
          if (in_held_band) begin
            cand_r  <= held_r;
            state_r <= S_UPD;
          end else begin
            state_r <= S_BDIV;
          end
        end
        S_BDIV: begin
          if (div_stat.done) begin
            // The top of the hue range may land one past the last band.
            cand_r  <= (div_q[4:0] >= n_bands) ? (n_bands - 5'd1) : div_q[4:0];
            state_r <= S_UPD;
          end
        end
        S_UPD: begin
          if (color_valid_r) begin
            if (degree_valid_r && (cand_r == held_r)) begin
              pend_valid_r <= 1'b0;
              dwell_r      <= 8'd0;
            end else if (!pend_valid_r || (cand_r != pend_r)) begin
              pend_valid_r <= 1'b1;
              pend_r       <= cand_r;
              dwell_r      <= 8'd0;
            end else if (dwell_inc >= 9'(DWELL_TICKS)) begin
              degree_valid_r <= 1'b1;
              held_r         <= cand_r;
              pend_valid_r   <= 1'b0;
              dwell_r        <= 8'd0;
              trig_cnt_r     <= trig_ticks_r;
            end else begin
              dwell_r <= dwell_inc[7:0];
            end
          end else begin
            pend_valid_r <= 1'b0;
            dwell_r      <= 8'd0;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (out_free) begin
            out_data_r.note        <= degree_valid_r ? mapped_note : 7'd0;
            out_data_r.note_held   <= degree_valid_r;
            out_data_r.led_flash   <= flash_r;
            out_data_r.trigger     <= trig_now;
            out_data_r.color_valid <= color_valid_r;
            out_data_r.gate        <= color_valid_r && degree_valid_r;
            out_valid_r            <= 1'b1;
            if (trig_now) begin
              trig_cnt_r <= trig_cnt_r - 8'd1;
            end
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

`ifndef ASSERT_OFF
  // The sequencer never restarts the divider in the middle of a division.
  a_div_idle_at_start: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  // A commit clears the dwell count, so it never reaches the dwell length.
  a_dwell_bound: assert property (@(posedge clk) disable iff (!rst_n)
    dwell_r < 8'(DWELL_TICKS))
    else $error("dwell count reached its limit");

  // A held degree always names a band of the current scale.
  a_held_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    degree_valid_r |-> (held_r < scale_bands(cur_scale_r)))
    else $error("held degree outside the band range");

  // A result only appears after the sequencer went through its output step.
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_OUT))
    else $error("result raised outside the output step");

  // A sample that gave no hue never opens the gate.
  a_gate_needs_color: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (!out_data_r.gate || (out_data_r.color_valid && out_data_r.note_held)))
    else $error("gate high without colour and held note");
`endif

endmodule
